FILE: src/context_ready_queue_core_macros.svh
// assertion macros for the context ready queue checker
// no dependencies; included by the checker file only
`ifndef CONTEXT_READY_QUEUE_CORE_MACROS_SVH
`define CONTEXT_READY_QUEUE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define CRQ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define CRQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/crq_pkg.sv
// shared types, sizes and operation codes of the context ready queue
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package crq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  context_handle;
    logic [15:0] process_id;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  removed_handle;
    logic [15:0] removed_id;
    logic [4:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic                   hit;
    logic [QUEUE_DEPTH-1:0] sel;
    logic [QUEUE_DEPTH-1:0] shift_mask;
  } pick_t;

endpackage

`default_nettype wire

FILE: src/context_ready_queue_core.sv
// context ready queue: ordered store of (handle, process id) entries in a row
// of cells. push appends at the tail; pop takes the head; remove-by-id takes
// the head if it matches, else the tail, else the earliest match. slots behind
// a removed entry all move forward one place in the same cycle, so the row has
// no gaps. every item produces one result item in the cycle after acceptance;
// throughput is one item per cycle, set by the combinational compare across all
// cells and the one-step shift. a new item is taken whenever the result
// register is empty or being drained. depends on crq_pkg, crq_cell, crq_pick
`timescale 1ns / 1ps
`default_nettype none

module context_ready_queue_core (
  input  wire           clk,
  input  wire           rst,
  input  wire           req_valid,
  output logic          req_ready,
  input  crq_pkg::req_t req,
  output logic          rsp_valid,
  input  wire           rsp_ready,
  output crq_pkg::rsp_t rsp
);
  import crq_pkg::*;

  // occupancy of the row
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  // per-cell views
  logic [7:0]             cell_handle [QUEUE_DEPTH];
  logic [15:0]            cell_id     [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] cell_match;
  cell_ctrl_t             cell_ctrl   [QUEUE_DEPTH];

  pick_t       pick;
  logic        accept;
  logic        push_ok;
  logic        take_ok;
  logic [7:0]  taken_handle;
  logic [15:0] taken_id;
  rsp_t        rsp_next;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;

  // push needs a non-null handle and a free slot
  assign push_ok = (req.opcode == OP_PUSH) && (req.context_handle != 8'd0) &&
                   (count < CNT_W'(QUEUE_DEPTH));
  assign take_ok = pick.hit;

  crq_pick u_pick (
    .opcode (req.opcode),
    .key    (req.process_id),
    .count  (count),
    .match  (cell_match),
    .pick   (pick)
  );

  // row of cells; each takes its neighbour's entry when the row closes up
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [7:0]  nbr_handle;
    logic [15:0] nbr_id;

    if (i < QUEUE_DEPTH - 1) begin : g_mid
      assign nbr_handle = cell_handle[i+1];
      assign nbr_id     = cell_id[i+1];
    end else begin : g_end
      assign nbr_handle = 8'd0;
      assign nbr_id     = 16'd0;
    end

    assign cell_ctrl[i].load  = accept && push_ok && (count == CNT_W'(i));
    assign cell_ctrl[i].shift = accept && take_ok && pick.shift_mask[i];

    crq_cell u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl[i]),
      .new_handle (req.context_handle),
      .new_id     (req.process_id),
      .nbr_handle (nbr_handle),
      .nbr_id     (nbr_id),
      .key        (req.process_id),
      .handle     (cell_handle[i]),
      .id         (cell_id[i]),
      .match      (cell_match[i])
    );
  end

  // one-hot select of the entry leaving the row
  always_comb begin
    taken_handle = 8'd0;
    taken_id     = 16'd0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      taken_handle = taken_handle | (cell_handle[i] & {8{pick.sel[i]}});
      taken_id     = taken_id | (cell_id[i] & {16{pick.sel[i]}});
    end
  end

  always_comb begin
    count_next = count;
    if (push_ok) begin
      count_next = count + CNT_W'(1);
    end else if (take_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_comb begin
    rsp_next.ok             = push_ok || take_ok;
    rsp_next.removed_handle = take_ok ? taken_handle : 8'd0;
    rsp_next.removed_id     = take_ok ? taken_id : 16'd0;
    rsp_next.occupancy      = 5'(count_next);
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/crq_cell.sv
// one queue slot: holds a handle and id, compares its id to the key
// depends on crq_pkg
`timescale 1ns / 1ps
`default_nettype none

module crq_cell (
  input  wire                 clk,
  input  crq_pkg::cell_ctrl_t ctrl,
  input  wire  [7:0]          new_handle,
  input  wire  [15:0]         new_id,
  input  wire  [7:0]          nbr_handle,
  input  wire  [15:0]         nbr_id,
  input  wire  [15:0]         key,
  output logic [7:0]          handle,
  output logic [15:0]         id,
  output logic                match
);
  import crq_pkg::*;

  // shift from the neighbour behind closes a gap; load appends at the tail
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      handle <= nbr_handle;
      id     <= nbr_id;
    end else if (ctrl.load) begin
      handle <= new_handle;
      id     <= new_id;
    end
  end

  assign match = (id == key);

endmodule

`default_nettype wire

FILE: src/crq_pick.sv
// chooses the slot to take out: head for pop; for remove, head, else tail, else earliest match
// depends on crq_pkg
`timescale 1ns / 1ps
`default_nettype none

module crq_pick (
  input  wire  [1:0]                  opcode,
  input  wire  [15:0]                 key,
  input  wire  [crq_pkg::CNT_W-1:0]   count,
  input  wire  [crq_pkg::QUEUE_DEPTH-1:0] match,
  output crq_pkg::pick_t              pick
);
  import crq_pkg::*;

  logic [QUEUE_DEPTH-1:0] live;
  logic [QUEUE_DEPTH-1:0] hits;
  logic [QUEUE_DEPTH-1:0] first;
  logic [QUEUE_DEPTH-1:0] tail_sel;
  logic [QUEUE_DEPTH-1:0] sel;
  logic [IDX_W-1:0]       last;
  logic                   hit;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_live
    assign live[i] = (CNT_W'(i) < count);
  end

  assign last     = IDX_W'(count - CNT_W'(1));
  assign hits     = match & live & {QUEUE_DEPTH{key != 16'd0}};
  // isolate lowest set bit
  assign first    = hits & (~hits + QUEUE_DEPTH'(1));
  assign tail_sel = QUEUE_DEPTH'(1) << last;

  always_comb begin
    hit = 1'b0;
    sel = '0;
    case (opcode)
      OP_POP: begin
        hit = (count != '0);
        sel = QUEUE_DEPTH'(1);
      end
      OP_REMOVE: begin
        hit = |hits;
        if (hits[0]) begin
          sel = QUEUE_DEPTH'(1);
        end else if (|(hits & tail_sel)) begin
          sel = tail_sel;
        end else begin
          sel = first;
        end
      end
      default: begin
        hit = 1'b0;
        sel = '0;
      end
    endcase
  end

  assign pick.hit        = hit;
  assign pick.sel        = sel;
  // every slot at or behind the chosen one moves forward
  assign pick.shift_mask = hit ? ~(sel - QUEUE_DEPTH'(1)) : '0;

endmodule

`default_nettype wire

FILE: src/crq_checker.sv
// port-level checks on the context ready queue, bound to the top level
// depends on crq_pkg and context_ready_queue_core_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "context_ready_queue_core_macros.svh"

module crq_checker (
  input wire           clk,
  input wire           rst,
  input wire           req_valid,
  input wire           req_ready,
  input wire           rsp_valid,
  input wire           rsp_ready,
  input crq_pkg::rsp_t rsp
);
  import crq_pkg::*;

  localparam logic [4:0] OCC_MAX = 5'(QUEUE_DEPTH);

  logic in_fire;
  logic rsp_stall;
  logic rsp_fail;
  logic rsp_empty;

  assign in_fire   = req_valid && req_ready;
  assign rsp_stall = rsp_valid && !rsp_ready;
  assign rsp_fail  = rsp_valid && !rsp.ok;
  assign rsp_empty = (rsp.removed_handle == 8'd0) && (rsp.removed_id == 16'd0);

  // stalled result holds
  `CRQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_stall, rsp_valid && $stable(rsp), "held result changed")
  // input only blocked by a waiting result
  `CRQ_ASSERT_NOW(a_ready_free, clk, rst, !req_ready, rsp_valid, "input stalled without a result")
  // each accepted item yields a result next cycle
  `CRQ_ASSERT_NEXT(a_rsp_follows, clk, rst, in_fire, rsp_valid, "accepted item gave no result")
  // occupancy bounded by depth
  `CRQ_ASSERT_NOW(a_occ_bound, clk, rst, rsp_valid, rsp.occupancy <= OCC_MAX, "occupancy too high")
  // failed operations report nothing removed
  `CRQ_ASSERT_NOW(a_fail_zero, clk, rst, rsp_fail, rsp_empty, "failed item reports removal")

endmodule

bind context_ready_queue_core crq_checker u_crq_checker (.*);

`default_nettype wire
